[rtl/core/aesctr_pkg.sv]
// shared types, s-box table and round functions for the aes-128 ctr engine
// no dependencies
package aesctr_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned CountW    = 5;
  localparam int unsigned MaxBytes  = 16;
  localparam int unsigned StepW     = 4;
  localparam int unsigned IndexW    = 8;

  localparam logic [IndexW-1:0] RegKeyHigh   = 8'd0;
  localparam logic [IndexW-1:0] RegKeyLow    = 8'd1;
  localparam logic [IndexW-1:0] RegNonceHigh = 8'd2;
  localparam logic [IndexW-1:0] RegNonceLow  = 8'd3;

  typedef logic [BlockW-1:0] block_t;

  // data and byte count riding along with the keystream
  typedef struct packed {
    logic [HalfW-1:0]  data_high;
    logic [HalfW-1:0]  data_low;
    logic [CountW-1:0] nbytes;
  } side_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(block_t v, int unsigned k);
    return v[BlockW-1-8*k -: 8];
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = Sbox[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c+1);
      a2  = get_byte(s, 4*c+2);
      a3  = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(4*c)   -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
      t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
      t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

[rtl/core/aesctr_key_exp.sv]
// key registers and sequential round key expansion, one round key per cycle
// depends on aesctr_pkg
module aesctr_key_exp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        key_wr_i,
  input  logic                        key_sel_low_i,
  input  logic [aesctr_pkg::HalfW-1:0] key_data_i,
  output logic                        busy_o,
  output aesctr_pkg::block_t          round_key_o [aesctr_pkg::NumRounds+1]
);
  import aesctr_pkg::*;

  logic [HalfW-1:0] key_high_q, key_low_q;
  block_t           prev_q, next_key;
  logic [7:0]       rcon_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  block_t           rk_q [NumRounds+1];
  logic [31:0]      rot, subw, w0, w1, w2, w3;

  always_comb begin
    rot  = {prev_q[23:0], prev_q[31:24]};
    subw = {Sbox[rot[31:24]], Sbox[rot[23:16]], Sbox[rot[15:8]], Sbox[rot[7:0]]};
    w0   = prev_q[127:96] ^ subw ^ {rcon_q, 24'h0};
    w1   = prev_q[95:64] ^ w0;
    w2   = prev_q[63:32] ^ w1;
    w3   = prev_q[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  end

  // expansion restarts on reset and on every key request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      prev_q     <= '0;
      rcon_q     <= 8'h01;
      step_q     <= '0;
      busy_q     <= 1'b1;
    end else if (key_wr_i) begin
      if (key_sel_low_i) begin
        key_low_q <= key_data_i;
        prev_q    <= {key_high_q, key_data_i};
      end else begin
        key_high_q <= key_data_i;
        prev_q     <= {key_data_i, key_low_q};
      end
      rcon_q <= 8'h01;
      step_q <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (step_q != '0) begin
        prev_q <= next_key;
        rcon_q <= gf_double(rcon_q);
      end
      if (step_q == StepW'(NumRounds)) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !key_wr_i) begin
      rk_q[step_q] <= (step_q == '0) ? prev_q : next_key;
    end
  end

  assign busy_o      = busy_q;
  assign round_key_o = rk_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= StepW'(NumRounds))
    else $error("expansion step out of range");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !key_wr_i && step_q == StepW'(NumRounds) |=> !busy_q)
    else $error("expansion did not finish");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr_i |=> busy_q && step_q == '0)
    else $error("key request did not restart expansion");
endmodule

[rtl/core/aesctr_round.sv]
// one registered aes round stage; the final round skips mix columns
// depends on aesctr_pkg
module aesctr_round (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      last_i,
  input  aesctr_pkg::block_t        round_key_i,
  input  logic                      valid_i,
  input  aesctr_pkg::block_t        state_i,
  input  aesctr_pkg::side_t         side_i,
  output logic                      valid_o,
  output aesctr_pkg::block_t        state_o,
  output aesctr_pkg::side_t         side_o
);
  import aesctr_pkg::*;

  logic   valid_q;
  block_t state_q, state_d, ss;
  side_t  side_q;

  always_comb begin
    ss      = sub_shift(state_i);
    state_d = (last_i ? ss : mix_columns(ss)) ^ round_key_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign side_o  = side_q;
endmodule

[rtl/core/aes128_ctr_block_crypt.sv]
// aes-128 counter mode crypt engine top level: counter add, round pipeline, output
// depends on aesctr_pkg, aesctr_key_exp, aesctr_round
//
// usage
//   config: write key_high (0), key_low (1), nonce_high (2), nonce_low (3) on the
//   cfg channel (cfg_ready_o is always high). a key write starts a round
//   key expansion; in_stall_o stays high until it is done.
//   input: unless stalled, one request per cycle carries a 16-byte block, its block
//   index and valid byte count; the counter block is nonce + block index mod 2^128.
//   output: crypted block with bytes past the count zeroed, and the count
//   (saturated at 16).
//   pipeline: the counter stage, the key-add stage, ten round stages and the
//   output register; one block per cycle sustained while no stall holds it.
//   reset: config and valid registers clear, the zero key is expanded (input stalled).
//   when out_stall_i holds a waiting result the whole pipeline freezes and
//   in_stall_o rises; bubbles ahead of a held result do not advance.
module aes128_ctr_block_crypt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aesctr_pkg::IndexW-1:0]   cfg_index_i,
  input  logic [aesctr_pkg::HalfW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [aesctr_pkg::HalfW-1:0]    data_high_i,
  input  logic [aesctr_pkg::HalfW-1:0]    data_low_i,
  input  logic [aesctr_pkg::HalfW-1:0]    block_number_i,
  input  logic [aesctr_pkg::CountW-1:0]   valid_bytes_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [aesctr_pkg::HalfW-1:0]    result_high_o,
  output logic [aesctr_pkg::HalfW-1:0]    result_low_o,
  output logic [aesctr_pkg::CountW-1:0]   result_bytes_o
);
  import aesctr_pkg::*;

  logic             en, kbusy, cfg_wr;
  logic [HalfW-1:0] nonce_high_q, nonce_low_q;
  block_t           rk [NumRounds+1];

  logic   va_q, vb_q, vo_q;
  block_t ctr_q, stb_q, ks;
  side_t  side_a_q, side_b_q, side_in, side_end;
  logic [CountW-1:0] nsat;
  logic [BlockW-1:0] res_d, res_q, mask;
  logic [CountW-1:0] bytes_q;

  logic   rv [NumRounds+1];
  block_t rs [NumRounds+1];
  side_t  rside [NumRounds+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_high_q <= '0;
      nonce_low_q  <= '0;
    end else if (cfg_wr) begin
      if (cfg_index_i == RegNonceHigh) nonce_high_q <= cfg_data_i;
      if (cfg_index_i == RegNonceLow)  nonce_low_q  <= cfg_data_i;
    end
  end

  aesctr_key_exp u_kexp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_wr_i      (cfg_wr && (cfg_index_i == RegKeyHigh || cfg_index_i == RegKeyLow)),
    .key_sel_low_i (cfg_index_i == RegKeyLow),
    .key_data_i    (cfg_data_i),
    .busy_o        (kbusy),
    .round_key_o   (rk)
  );

  assign en         = !(vo_q && out_stall_i);
  assign in_stall_o = kbusy || !en;

  assign nsat    = (valid_bytes_i > CountW'(MaxBytes)) ? CountW'(MaxBytes) : valid_bytes_i;
  assign side_in = '{data_high: data_high_i, data_low: data_low_i, nbytes: nsat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en) begin
        va_q <= in_valid_i && !in_stall_o;
        vb_q <= va_q;
      end
      if (en) vo_q <= rv[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctr_q    <= {nonce_high_q, nonce_low_q} + {{HalfW{1'b0}}, block_number_i};
      side_a_q <= side_in;
      stb_q    <= ctr_q ^ rk[0];
      side_b_q <= side_a_q;
      res_q    <= res_d;
      bytes_q  <= side_end.nbytes;
    end
  end

  assign rv[0]    = vb_q;
  assign rs[0]    = stb_q;
  assign rside[0] = side_b_q;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aesctr_round u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .last_i      (g == NumRounds),
      .round_key_i (rk[g]),
      .valid_i     (rv[g-1]),
      .state_i     (rs[g-1]),
      .side_i      (rside[g-1]),
      .valid_o     (rv[g]),
      .state_o     (rs[g]),
      .side_o      (rside[g])
    );
  end

  assign ks       = rs[NumRounds];
  assign side_end = rside[NumRounds];

  // keep byte k only when k is below the count
  always_comb begin
    mask = '0;
    for (int unsigned k = 0; k < MaxBytes; k++) begin
      mask[BlockW-1-8*k -: 8] = (CountW'(k) < side_end.nbytes) ? 8'hff : 8'h00;
    end
    res_d = ({side_end.data_high, side_end.data_low} ^ ks) & mask;
  end

  assign out_valid_o    = vo_q;
  assign result_high_o  = res_q[BlockW-1:HalfW];
  assign result_low_o   = res_q[HalfW-1:0];
  assign result_bytes_o = bytes_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kbusy |-> in_stall_o)
    else $error("input taken during key expansion");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_bytes_o))
    else $error("held result lost");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_bytes_o <= CountW'(MaxBytes))
    else $error("byte count not saturated");
endmodule

[tb/aes128_ctr_block_crypt_tb.sv]
// self-checking testbench for the aes-128 ctr block crypt engine
// depends on aesctr_pkg and aes128_ctr_block_crypt; carries its own cipher predictor
module aes128_ctr_block_crypt_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aesctr_pkg::*;

  localparam logic [IndexW-1:0] RegUnusedLow = 8'd4;
  localparam logic [IndexW-1:0] RegUnusedTop = 8'hff;
  localparam int unsigned       DrainCycles  = 24;
  localparam int unsigned       PhaseBlocks  = 170;

  typedef struct packed {
    logic [HalfW-1:0]  hi;
    logic [HalfW-1:0]  lo;
    logic [CountW-1:0] n;
  } crypt_res_t;

  typedef struct {
    logic [HalfW-1:0]  dh;
    logic [HalfW-1:0]  dl;
    logic [HalfW-1:0]  bn;
    logic [CountW-1:0] vb;
    bit                fixed;
    crypt_res_t        res;
  } block_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IndexW-1:0] cfg_index_i = '0;
  logic [HalfW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [HalfW-1:0] data_high_i = '0;
  logic [HalfW-1:0] data_low_i = '0;
  logic [HalfW-1:0] block_number_i = '0;
  logic [CountW-1:0] valid_bytes_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [HalfW-1:0] result_high_o;
  logic [HalfW-1:0] result_low_o;
  logic [CountW-1:0] result_bytes_o;

  aes128_ctr_block_crypt u_dut (.*);

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]       sub_tbl [256];
  logic [127:0]     round_keys [NumRounds+1];
  logic [HalfW-1:0] key_hi, key_lo, nonce_hi, nonce_lo;
  crypt_res_t       pending_results [$];
  int               mismatches = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // s-box from the field inverse and the affine map
  function automatic void build_sub_tbl();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256 && x != 0; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tbl[x] = s;
    end
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [4*(NumRounds+1)];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
    for (int i = 4; i < 4*(NumRounds+1); i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_tbl[t[31:24]], sub_tbl[t[23:16]], sub_tbl[t[15:8]], sub_tbl[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r <= NumRounds; r++) begin
      round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    end
  endfunction

  function automatic logic [127:0] encrypt_counter(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8] ^ round_keys[0][127-8*k -: 8];
    for (int r = 1; r <= NumRounds; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int q = 0; q < 4; q++) t[q+4*c] = sub_tbl[s[q + 4*((c+q) % 4)]];
      end
      s = t;
      if (r != NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ all ^ gf_mul(a0 ^ a1, 8'h02);
          s[4*c+1] = a1 ^ all ^ gf_mul(a1 ^ a2, 8'h02);
          s[4*c+2] = a2 ^ all ^ gf_mul(a2 ^ a3, 8'h02);
          s[4*c+3] = a3 ^ all ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (int k = 0; k < 16; k++) s[k] ^= round_keys[r][127-8*k -: 8];
    end
    for (int k = 0; k < 16; k++) blk[127-8*k -: 8] = s[k];
    return blk;
  endfunction

  function automatic crypt_res_t ctr_crypt(logic [HalfW-1:0] dh, logic [HalfW-1:0] dl,
                                           logic [HalfW-1:0] bn, logic [CountW-1:0] vb);
    crypt_res_t   res;
    logic [127:0] ks, txt;
    int           n;
    n   = (vb > MaxBytes) ? MaxBytes : vb;
    ks  = encrypt_counter({nonce_hi, nonce_lo} + {64'h0, bn});
    txt = {dh, dl} ^ ks;
    for (int k = 0; k < 16; k++) begin
      if (k >= n) txt[127-8*k -: 8] = 8'h00;
    end
    res.hi = txt[127:64];
    res.lo = txt[63:0];
    res.n  = n[CountW-1:0];
    return res;
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IndexW-1:0] idx, logic [HalfW-1:0] val);
    in_valid_i <= 1'b0;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegKeyHigh: begin key_hi = val; expand_round_keys(); end
      RegKeyLow: begin key_lo = val; expand_round_keys(); end
      RegNonceHigh: nonce_hi = val;
      RegNonceLow: nonce_lo = val;
      default: ;
    endcase
  endtask

  task automatic send_block(logic [HalfW-1:0] dh, logic [HalfW-1:0] dl, logic [HalfW-1:0] bn,
                            logic [CountW-1:0] vb, bit fixed, crypt_res_t fixed_res);
    crypt_res_t res;
    res = fixed ? fixed_res : ctr_crypt(dh, dl, bn, vb);
    in_valid_i     <= 1'b1;
    data_high_i    <= dh;
    data_low_i     <= dl;
    block_number_i <= bn;
    valid_bytes_i  <= vb;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [HalfW-1:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [HalfW-1:0] rand_index();
    case ($urandom_range(3))
      0: return HalfW'($urandom_range(40));
      1: return '1 - HalfW'($urandom_range(8));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    case ($urandom_range(9))
      0: return CountW'($urandom_range(31));
      1, 2: return CountW'($urandom_range(15, 1));
      default: return CountW'(MaxBytes);
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    crypt_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %0d",
                                       result_high_o, result_low_o, result_bytes_o);
      end else begin
        want = pending_results.pop_front();
        if (result_high_o !== want.hi || result_low_o !== want.lo ||
            result_bytes_o !== want.n) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %h %h %0d got %h %h %0d",
                                         want.hi, want.lo, want.n,
                                         result_high_o, result_low_o, result_bytes_o);
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    block_row_t rows [$];
    crypt_res_t none;
    int         limit;
    none = '0;
    build_sub_tbl();
    key_hi = '0; key_lo = '0; nonce_hi = '0; nonce_lo = '0;
    expand_round_keys();

    // zero key, zero counter gives the textbook keystream
    rows.push_back('{'0, '0, '0, 5'd16, 1'b1,
                     '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 5'd16}});
    rows.push_back('{'1, '1, '0, 5'd0, 1'b1, none});
    rows.push_back('{'1, '1, '1, 5'd0, 1'b1, none});
    rows.push_back('{'1, '1, '0, 5'd16, 1'b1,
                     '{~64'h66e94bd4ef8a2c3b, ~64'h884cfa59ca342b2e, 5'd16}});
    rows.push_back('{'1, '0, 64'd1, 5'd1, 1'b0, none});
    rows.push_back('{'0, '1, 64'd2, 5'd8, 1'b0, none});
    rows.push_back('{'1, '1, '1, 5'd15, 1'b0, none});
    rows.push_back('{64'h0123456789abcdef, 64'hfedcba9876543210, 64'h8000000000000000,
                     5'd17, 1'b0, none});
    rows.push_back('{'1, '1, 64'h5555555555555555, 5'd31, 1'b0, none});
    rows.push_back('{'0, '0, 64'haaaaaaaaaaaaaaaa, 5'd9, 1'b0, none});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) send_block(rows[i].dh, rows[i].dl, rows[i].bn, rows[i].vb,
                                 rows[i].fixed, rows[i].res);
    in_valid_i <= 1'b0;

    // counter wrap past 2^128, and the all-ones key
    write_reg(RegNonceHigh, '1);
    write_reg(RegNonceLow, '1);
    write_reg(RegUnusedLow, 64'h1234);
    write_reg(RegUnusedTop, '1);
    send_block('0, '0, 64'd0, 5'd16, 1'b0, none);
    send_block('0, '0, 64'd1, 5'd16, 1'b0, none);
    send_block('1, '0, '1, 5'd16, 1'b0, none);
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    send_block('0, '1, 64'd3, 5'd16, 1'b0, none);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      write_reg(RegKeyHigh, rand_word());
      write_reg(RegKeyLow, rand_word());
      write_reg(RegNonceHigh, rand_word());
      write_reg(RegNonceLow, (ph == 3) ? '0 : rand_word());
      for (int i = 0; i < PhaseBlocks; i++) begin
        // let the pipeline run dry once
        if (ph == 1 && i == PhaseBlocks / 2) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_block({$urandom(), $urandom()}, {$urandom(), $urandom()}, rand_index(),
                   rand_count(), 1'b0, none);
      end
      in_valid_i <= 1'b0;
    end

    stall_pct = 0;
    limit = 0;
    while (pending_results.size() != 0 && limit < 5000) begin
      @(posedge clk_i);
      limit++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
